### rtl/core/nnvo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nnvo_pkg: shared types and constants of the nearest-neighbor visit order
// Sizes of the point store and coordinates, command words, state encodings.
// ----------------------------------------------------------------------------
package nnvo_pkg;

	localparam int MAX_POINTS  = 64;
	localparam int COORD_BITS  = 16;
	localparam int IDX_W       = $clog2(MAX_POINTS);
	localparam int CNT_W       = IDX_W + 1;

	// Stream field widths, fixed by the interface.
	localparam int FIELD_W     = 16;
	localparam int RANK_W      = 6;
	localparam int SRC_W       = 6;
	localparam int IN_TDATA_W  = 3 * FIELD_W;
	localparam int OUT_PLD_W   = RANK_W + SRC_W + 3 * FIELD_W;
	localparam int OUT_TDATA_W = ((OUT_PLD_W + 7) / 8) * 8;

	// Exact squared distance: difference, square, sum of three squares.
	localparam int DIFF_W      = COORD_BITS + 1;
	localparam int SQ_W        = 2 * DIFF_W;
	localparam int DIST_W      = SQ_W + 2;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = QPTR_W + 1;

	localparam logic OP_SET_START  = 1'b0;
	localparam logic OP_LOAD_POINT = 1'b1;

	typedef logic [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		coord_t z;
		coord_t y;
		coord_t x;
	} point_t;

	localparam int POINT_W = $bits(point_t);

	typedef enum logic [1:0] {
		CMD_START,
		CMD_LOAD,
		CMD_LOAD_FINAL
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		point_t    pos;
	} cmd_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SCAN,
		BK_EMIT
	} back_state_t;

endpackage
`default_nettype wire

### rtl/core/nnvo_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nnvo_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module nnvo_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

### rtl/core/nnvo_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nnvo_front: input word decode and command queue
// Turns each accepted input word into a command and holds it in a short
// queue until the ordering engine takes it.
// ----------------------------------------------------------------------------
module nnvo_front import nnvo_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_TDATA_W-1:0] s_tdata,  // pos_x, pos_y, pos_z
	input  wire logic                  s_tuser,  // opcode
	input  wire logic                  s_tlast,  // final_point
	output logic                       q_valid,
	input  wire logic                  q_ready,
	output cmd_t                       q_cmd
);

	cmd_t              fifo_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] fill_q;
	cmd_t              cmd_in;
	logic              push;
	logic              pop;

	// Only the low COORD_BITS of each field are significant.
	always_comb begin
		cmd_in.pos.x = s_tdata[COORD_BITS-1:0];
		cmd_in.pos.y = s_tdata[FIELD_W +: COORD_BITS];
		cmd_in.pos.z = s_tdata[2*FIELD_W +: COORD_BITS];
		if (s_tuser == OP_SET_START) begin
			cmd_in.kind = CMD_START;
		end else if (s_tlast) begin
			cmd_in.kind = CMD_LOAD_FINAL;
		end else begin
			cmd_in.kind = CMD_LOAD;
		end
	end

	assign s_tready = (fill_q != QCNT_W'(QUEUE_DEPTH));
	assign q_valid  = (fill_q != '0);
	assign q_cmd    = fifo_q[rd_ptr_q];
	assign push     = s_tvalid && s_tready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

### rtl/core/nnvo_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nnvo_back: point store and greedy ordering engine
// Executes queued commands. A final point starts the ordering: for each rank
// the engine streams all stored points through a three-stage distance
// pipeline, keeps the nearest unvisited one and emits it.
// ----------------------------------------------------------------------------
module nnvo_back import nnvo_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   q_valid,
	output logic                        q_ready,
	input  wire cmd_t                   q_cmd,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [OUT_TDATA_W-1:0]      m_tdata,  // visit_rank, source_index,
	                                              // out_x, out_y, out_z, pad
	output logic                        m_tuser,  // dropped
	output logic                        m_tlast   // run_end
);

	back_state_t state_q, state_d;

	logic [CNT_W-1:0]      count_q;
	logic                  overflow_q;
	point_t                start_q;
	point_t                cur_q;
	logic [MAX_POINTS-1:0] visited_q;
	logic [IDX_W-1:0]      rank_q;
	logic [CNT_W-1:0]      issue_q;

	logic                  v_s1_q;
	logic [IDX_W-1:0]      idx_s1;
	point_t                ram_rdata;

	logic                  v_s2_q;
	logic [IDX_W-1:0]      idx_s2;
	point_t                pt_s2;
	logic [SQ_W-1:0]       sq_s2 [3];

	logic                  v_s3_q;
	logic [IDX_W-1:0]      idx_s3;
	point_t                pt_s3;
	logic [DIST_W-1:0]     dist_s3;

	logic                  found_q;
	logic [DIST_W-1:0]     best_d_q;
	logic [IDX_W-1:0]      best_idx_q;
	point_t                best_pt_q;

	logic                  out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;
	logic                  out_last_q;
	logic                  out_drop_q;

	logic                  pop;
	logic                  store_we;
	logic                  issue_en;
	logic                  scan_done;
	logic                  load_out;
	logic                  last_rank;
	logic                  take;

	logic signed [DIFF_W-1:0] diff [3];
	logic signed [SQ_W-1:0]   prod [3];
	coord_t                   pt_c [3];
	coord_t                   cur_c [3];

	assign store_we = pop && (q_cmd.kind != CMD_START) &&
	                  (count_q != CNT_W'(MAX_POINTS));

	nnvo_ram #(
		.WIDTH (POINT_W),
		.DEPTH (MAX_POINTS)
	) u_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (q_cmd.pos),
		.raddr (issue_q[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	assign issue_en  = (state_q == BK_SCAN) && (issue_q != count_q);
	assign scan_done = (issue_q == count_q) && !v_s1_q && !v_s2_q && !v_s3_q;
	assign last_rank = (CNT_W'(rank_q) + 1'b1 == count_q);
	assign take      = v_s3_q && !visited_q[idx_s3] &&
	                   (!found_q || (dist_s3 < best_d_q));

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				pop = q_valid;
				if (q_valid && (q_cmd.kind == CMD_LOAD_FINAL)) begin
					state_d = BK_SCAN;
				end
			end
			BK_SCAN: begin
				if (scan_done) begin
					state_d = BK_EMIT;
				end
			end
			BK_EMIT: begin
				if (!out_valid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = last_rank ? BK_IDLE : BK_SCAN;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	assign q_ready = (state_q == BK_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Distance pipeline datapath.
	assign pt_c[0]  = ram_rdata.x;
	assign pt_c[1]  = ram_rdata.y;
	assign pt_c[2]  = ram_rdata.z;
	assign cur_c[0] = cur_q.x;
	assign cur_c[1] = cur_q.y;
	assign cur_c[2] = cur_q.z;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			diff[k] = $signed({pt_c[k][COORD_BITS-1], pt_c[k]}) -
			          $signed({cur_c[k][COORD_BITS-1], cur_c[k]});
			prod[k] = diff[k] * diff[k];
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= issue_q[IDX_W-1:0];
		idx_s2 <= idx_s1;
		pt_s2  <= ram_rdata;
		for (int k = 0; k < 3; k++) begin
			sq_s2[k] <= unsigned'(prod[k]);
		end
		idx_s3  <= idx_s2;
		pt_s3   <= pt_s2;
		dist_s3 <= DIST_W'(sq_s2[0]) + DIST_W'(sq_s2[1]) + DIST_W'(sq_s2[2]);
		if (take) begin
			best_d_q   <= dist_s3;
			best_idx_q <= idx_s3;
			best_pt_q  <= pt_s3;
		end
		if (pop && (q_cmd.kind == CMD_LOAD_FINAL)) begin
			cur_q <= start_q;
		end else if (load_out) begin
			cur_q <= best_pt_q;
		end
		if (load_out) begin
			out_data_q <= OUT_TDATA_W'({FIELD_W'(best_pt_q.z), FIELD_W'(best_pt_q.y),
			                            FIELD_W'(best_pt_q.x), SRC_W'(best_idx_q),
			                            RANK_W'(rank_q)});
			out_last_q <= last_rank;
			out_drop_q <= overflow_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			overflow_q  <= 1'b0;
			start_q     <= '0;
			visited_q   <= '0;
			rank_q      <= '0;
			issue_q     <= '0;
			v_s1_q      <= 1'b0;
			v_s2_q      <= 1'b0;
			v_s3_q      <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1_q <= issue_en;
			v_s2_q <= v_s1_q;
			v_s3_q <= v_s2_q;
			if (issue_en) begin
				issue_q <= issue_q + 1'b1;
			end
			if (take) begin
				found_q <= 1'b1;
			end
			if (pop && (q_cmd.kind == CMD_START)) begin
				start_q <= q_cmd.pos;
			end
			if (pop && (q_cmd.kind != CMD_START)) begin
				if (count_q != CNT_W'(MAX_POINTS)) begin
					count_q <= count_q + 1'b1;
				end else begin
					overflow_q <= 1'b1;
				end
			end
			if (pop && (q_cmd.kind == CMD_LOAD_FINAL)) begin
				rank_q  <= '0;
				issue_q <= '0;
				found_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
				issue_q     <= '0;
				found_q     <= 1'b0;
				if (last_rank) begin
					// The set is consumed; the start position stays.
					visited_q  <= '0;
					count_q    <= '0;
					overflow_q <= 1'b0;
				end else begin
					visited_q[best_idx_q] <= 1'b1;
					rank_q <= rank_q + 1'b1;
				end
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_drop_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_POINTS))
		else $error("point count above capacity");

	a_emit_found: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_EMIT |-> found_q)
		else $error("no unvisited point found for a rank");

	a_pick_unvisited: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> !visited_q[best_idx_q])
		else $error("emitted a point that was already visited");

	a_run_clears: assert property (@(posedge clk) disable iff (!arst_n)
		load_out && last_rank |=> count_q == '0 && visited_q == '0 && !overflow_q)
		else $error("set not cleared after the last result");

	a_pipe_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3_q |-> state_q == BK_SCAN)
		else $error("distance pipeline active outside a scan");

endmodule
`default_nettype wire

### rtl/core/nearest_neighbor_visit_order_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_neighbor_visit_order_top: greedy nearest-neighbor tour of 3-D points
// Loads a start position and a set of points, then streams them out in
// greedy nearest-neighbor order.
// ----------------------------------------------------------------------------
// Send a word with tuser 0 to set the start position, then one word per point
// with tuser 1, tlast on the last one. Load and start words are taken one per
// cycle while the queue has room, through a two-word queue. The tlast word
// starts the ordering; for a set of N points each of the N ranks streams all
// N stored points through the single read port of the point memory and a
// three-stage distance pipeline; an output stall holds the engine before the
// next rank. Ties go to the earlier loaded point. Points beyond 64 are
// discarded and every result of that set has tuser set. The start position
// is kept across sets.
// ----------------------------------------------------------------------------
module nearest_neighbor_visit_order_top import nnvo_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,  // pos_x, pos_y, pos_z
	input  wire logic                   s_tuser,  // opcode
	input  wire logic                   s_tlast,  // final_point
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [OUT_TDATA_W-1:0]      m_tdata,  // visit_rank, source_index,
	                                              // out_x, out_y, out_z, pad
	output logic                        m_tuser,  // dropped
	output logic                        m_tlast   // run_end
);

	logic q_valid;
	logic q_ready;
	cmd_t q_cmd;

	nnvo_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_cmd    (q_cmd)
	);

	nnvo_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_cmd    (q_cmd),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
`default_nettype wire
